// File: sv/npe_pkg.sv
package npe_pkg;

  localparam int unsigned MAX_LEN    = 16;
  localparam int unsigned ELEM_WIDTH = 32;
  localparam int unsigned IDX_W      = $clog2(MAX_LEN);
  localparam int unsigned CNT_W      = $clog2(MAX_LEN + 1);

  typedef logic [ELEM_WIDTH-1:0] elem_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef enum logic [1:0] {
    AA_PTR_M1,
    AA_PIVOT,
    AA_LO,
    AA_PTR
  } addr_a_e;

  typedef enum logic {
    AB_PTR,
    AB_HI
  } addr_b_e;

  typedef enum logic [2:0] {
    WS_NONE,
    WS_PIVOT_B,
    WS_PTR_A,
    WS_LO_B,
    WS_HI_A
  } wr_sel_e;

  typedef enum logic [2:0] {
    PO_HOLD,
    PO_LAST,
    PO_DEC,
    PO_INC,
    PO_ZERO
  } ptr_op_e;

  typedef enum logic [1:0] {
    LH_HOLD,
    LH_WRAP,
    LH_PIVOT,
    LH_STEP
  } lohi_op_e;

  // Datapath controls carried by one microinstruction.
  typedef struct packed {
    logic     load_en;
    logic     rd_en;
    addr_a_e  addr_a;
    addr_b_e  addr_b;
    wr_sel_e  wr_sel;
    ptr_op_e  ptr_op;
    lohi_op_e lohi_op;
    logic     pivot_ld;
    logic     set_wrap;
    logic     emit_en;
    logic     finish;
  } dp_ctrl_t;

  // Conditions the datapath reports back for the jump logic.
  typedef struct packed {
    logic in_last_acc;
    logic n_one;
    logic less;
    logic ptr_one;
    logic lo_ge_hi;
    logic out_room;
    logic ptr_last;
  } dp_status_t;

  // Low ELEM_WIDTH bits of the sign-extended input word.
  function automatic elem_t to_elem(logic [31:0] v);
    logic [63:0] w;
    w = {{32{v[31]}}, v};
    return w[ELEM_WIDTH-1:0];
  endfunction

  // Sign-extend a stored element and keep the low 32 bits.
  function automatic logic [31:0] to_out(elem_t e);
    logic [63:0] w;
    w = 64'($signed(e));
    return w[31:0];
  endfunction

endpackage

// File: sv/npe_sequencer.sv
module npe_sequencer
  import npe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_status_t status_i,
  output dp_ctrl_t   ctrl_o
);

  typedef enum logic [4:0] {
    ST_LOAD      = 5'd0,
    ST_SCAN_INIT = 5'd1,
    ST_SCAN_RD   = 5'd2,
    ST_SCAN_CMP  = 5'd3,
    ST_SCAN_NXT  = 5'd4,
    ST_WRAP      = 5'd5,
    ST_FIND_INIT = 5'd6,
    ST_FIND_RD   = 5'd7,
    ST_FIND_CMP  = 5'd8,
    ST_FIND_DEC  = 5'd9,
    ST_SWAP1     = 5'd10,
    ST_SWAP2     = 5'd11,
    ST_REV_RD    = 5'd12,
    ST_REV_W1    = 5'd13,
    ST_REV_W2    = 5'd14,
    ST_EMIT_INIT = 5'd15,
    ST_EMIT_RD   = 5'd16,
    ST_EMIT_PUT  = 5'd17,
    ST_EMIT_NXT  = 5'd18,
    ST_FINISH    = 5'd19
  } step_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_IN_LAST,
    C_N_ONE,
    C_LESS,
    C_PTR_ONE,
    C_LO_GE_HI,
    C_OUT_ROOM,
    C_PTR_LAST
  } cond_e;

  typedef struct packed {
    cond_e    cond;
    logic     inv;
    step_e    target;
    dp_ctrl_t dp;
  } uword_t;

  // Microprogram. A word jumps to its target when its condition (optionally
  // inverted) holds, and falls through to the next step otherwise.
  function automatic uword_t ucode(step_e s);
    uword_t w;
    w = '{cond: C_NEVER, inv: 1'b0, target: ST_LOAD,
          dp: '{load_en: 1'b0, rd_en: 1'b0, addr_a: AA_PTR, addr_b: AB_PTR,
                wr_sel: WS_NONE, ptr_op: PO_HOLD, lohi_op: LH_HOLD,
                pivot_ld: 1'b0, set_wrap: 1'b0, emit_en: 1'b0, finish: 1'b0}};
    case (s)
      ST_LOAD: begin
        w.dp.load_en = 1'b1;
        w.cond = C_IN_LAST;
        w.inv = 1'b1;
        w.target = ST_LOAD;
      end
      ST_SCAN_INIT: begin
        w.dp.ptr_op = PO_LAST;
        w.cond = C_N_ONE;
        w.target = ST_WRAP;
      end
      ST_SCAN_RD: begin
        w.dp.rd_en = 1'b1;
        w.dp.addr_a = AA_PTR_M1;
        w.dp.addr_b = AB_PTR;
      end
      ST_SCAN_CMP: begin
        w.dp.pivot_ld = 1'b1;
        w.cond = C_LESS;
        w.target = ST_FIND_INIT;
      end
      ST_SCAN_NXT: begin
        w.dp.ptr_op = PO_DEC;
        w.cond = C_PTR_ONE;
        w.inv = 1'b1;
        w.target = ST_SCAN_RD;
      end
      ST_WRAP: begin
        w.dp.set_wrap = 1'b1;
        w.dp.lohi_op = LH_WRAP;
        w.cond = C_ALWAYS;
        w.target = ST_REV_RD;
      end
      ST_FIND_INIT: begin
        w.dp.ptr_op = PO_LAST;
      end
      ST_FIND_RD: begin
        w.dp.rd_en = 1'b1;
        w.dp.addr_a = AA_PIVOT;
        w.dp.addr_b = AB_PTR;
      end
      ST_FIND_CMP: begin
        w.cond = C_LESS;
        w.target = ST_SWAP1;
      end
      ST_FIND_DEC: begin
        w.dp.ptr_op = PO_DEC;
        w.cond = C_ALWAYS;
        w.target = ST_FIND_RD;
      end
      ST_SWAP1: begin
        w.dp.wr_sel = WS_PIVOT_B;
      end
      ST_SWAP2: begin
        w.dp.wr_sel = WS_PTR_A;
        w.dp.lohi_op = LH_PIVOT;
      end
      ST_REV_RD: begin
        w.dp.rd_en = 1'b1;
        w.dp.addr_a = AA_LO;
        w.dp.addr_b = AB_HI;
        w.cond = C_LO_GE_HI;
        w.target = ST_EMIT_INIT;
      end
      ST_REV_W1: begin
        w.dp.wr_sel = WS_LO_B;
      end
      ST_REV_W2: begin
        w.dp.wr_sel = WS_HI_A;
        w.dp.lohi_op = LH_STEP;
        w.cond = C_ALWAYS;
        w.target = ST_REV_RD;
      end
      ST_EMIT_INIT: begin
        w.dp.ptr_op = PO_ZERO;
      end
      ST_EMIT_RD: begin
        w.dp.rd_en = 1'b1;
        w.dp.addr_a = AA_PTR;
      end
      ST_EMIT_PUT: begin
        w.dp.emit_en = 1'b1;
        w.cond = C_OUT_ROOM;
        w.inv = 1'b1;
        w.target = ST_EMIT_PUT;
      end
      ST_EMIT_NXT: begin
        w.dp.ptr_op = PO_INC;
        w.cond = C_PTR_LAST;
        w.inv = 1'b1;
        w.target = ST_EMIT_RD;
      end
      ST_FINISH: begin
        w.dp.finish = 1'b1;
        w.cond = C_ALWAYS;
        w.target = ST_LOAD;
      end
      default: begin
        w.cond = C_ALWAYS;
        w.target = ST_LOAD;
      end
    endcase
    return w;
  endfunction

  step_e  upc_q, upc_d;
  uword_t word;
  logic   cond_val;

  always_comb begin
    word = ucode(upc_q);
    case (word.cond)
      C_NEVER:    cond_val = 1'b0;
      C_ALWAYS:   cond_val = 1'b1;
      C_IN_LAST:  cond_val = status_i.in_last_acc;
      C_N_ONE:    cond_val = status_i.n_one;
      C_LESS:     cond_val = status_i.less;
      C_PTR_ONE:  cond_val = status_i.ptr_one;
      C_LO_GE_HI: cond_val = status_i.lo_ge_hi;
      C_OUT_ROOM: cond_val = status_i.out_room;
      C_PTR_LAST: cond_val = status_i.ptr_last;
      default:    cond_val = 1'b0;
    endcase
    if (cond_val ^ word.inv) begin
      upc_d = word.target;
    end else begin
      upc_d = step_e'(upc_q + 5'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= ST_LOAD;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign ctrl_o = word.dp;

endmodule

// File: sv/npe_datapath.sv
module npe_datapath
  import npe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_ctrl_t    ctrl_i,
  output dp_status_t  status_o,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] elem_value_i,
  input  logic        is_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] out_value_o,
  output logic        out_last_o,
  output logic        wrapped_o,
  output logic        overflow_o
);

  elem_t mem [MAX_LEN];
  elem_t rd_a_q, rd_b_q;

  idx_t ptr_q, ptr_d;
  idx_t pivot_q;
  idx_t lo_q, lo_d;
  idx_t hi_q, hi_d;
  cnt_t cnt_q, cnt_d;
  logic ovf_q, ovf_d;
  logic wrap_q, wrap_d;

  logic [31:0] out_value_q;
  logic        out_last_q, wrapped_q, overflow_q;
  logic        out_valid_q;

  logic  in_acc, has_room, emit;
  idx_t  last_idx, addr_a, addr_b, wr_addr;
  elem_t wr_data;
  logic  wr_en;
  cnt_t  cnt_m1;

  assign in_stall_o = !ctrl_i.load_en;
  assign in_acc     = in_valid_i && ctrl_i.load_en;
  assign has_room   = cnt_q < CNT_W'(MAX_LEN);
  assign cnt_m1     = cnt_q - CNT_W'(1);
  assign last_idx   = cnt_m1[IDX_W-1:0];

  always_comb begin
    case (ctrl_i.addr_a)
      AA_PTR_M1: addr_a = ptr_q - IDX_W'(1);
      AA_PIVOT:  addr_a = pivot_q;
      AA_LO:     addr_a = lo_q;
      AA_PTR:    addr_a = ptr_q;
      default:   addr_a = ptr_q;
    endcase
    case (ctrl_i.addr_b)
      AB_PTR:  addr_b = ptr_q;
      AB_HI:   addr_b = hi_q;
      default: addr_b = ptr_q;
    endcase
  end

  // One write port, shared by loading, the pivot swap and the suffix reversal.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr_q;
    wr_data = rd_a_q;
    if (in_acc && has_room) begin
      wr_en   = 1'b1;
      wr_addr = cnt_q[IDX_W-1:0];
      wr_data = to_elem(elem_value_i);
    end else begin
      case (ctrl_i.wr_sel)
        WS_NONE: begin
          wr_en = 1'b0;
        end
        WS_PIVOT_B: begin
          wr_en   = 1'b1;
          wr_addr = pivot_q;
          wr_data = rd_b_q;
        end
        WS_PTR_A: begin
          wr_en   = 1'b1;
          wr_addr = ptr_q;
          wr_data = rd_a_q;
        end
        WS_LO_B: begin
          wr_en   = 1'b1;
          wr_addr = lo_q;
          wr_data = rd_b_q;
        end
        WS_HI_A: begin
          wr_en   = 1'b1;
          wr_addr = hi_q;
          wr_data = rd_a_q;
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctrl_i.rd_en) begin
      rd_a_q <= mem[addr_a];
      rd_b_q <= mem[addr_b];
    end
  end

  always_comb begin
    case (ctrl_i.ptr_op)
      PO_HOLD: ptr_d = ptr_q;
      PO_LAST: ptr_d = last_idx;
      PO_DEC:  ptr_d = ptr_q - IDX_W'(1);
      PO_INC:  ptr_d = ptr_q + IDX_W'(1);
      PO_ZERO: ptr_d = '0;
      default: ptr_d = ptr_q;
    endcase
    case (ctrl_i.lohi_op)
      LH_HOLD: begin
        lo_d = lo_q;
        hi_d = hi_q;
      end
      LH_WRAP: begin
        lo_d = '0;
        hi_d = last_idx;
      end
      LH_PIVOT: begin
        lo_d = pivot_q + IDX_W'(1);
        hi_d = last_idx;
      end
      LH_STEP: begin
        lo_d = lo_q + IDX_W'(1);
        hi_d = hi_q - IDX_W'(1);
      end
      default: begin
        lo_d = lo_q;
        hi_d = hi_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    if (ctrl_i.pivot_ld) begin
      pivot_q <= ptr_q - IDX_W'(1);
    end
  end

  always_comb begin
    cnt_d  = cnt_q;
    ovf_d  = ovf_q;
    wrap_d = wrap_q;
    if (in_acc) begin
      if (has_room) begin
        cnt_d = cnt_q + CNT_W'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
    if (ctrl_i.set_wrap) begin
      wrap_d = 1'b1;
    end
    if (ctrl_i.finish) begin
      cnt_d  = '0;
      ovf_d  = 1'b0;
      wrap_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
      wrap_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      ovf_q  <= ovf_d;
      wrap_q <= wrap_d;
    end
  end

  // The output register frees up in the same cycle its transaction completes.
  assign emit = ctrl_i.emit_en && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_value_q <= to_out(rd_a_q);
      out_last_q  <= (ptr_q == last_idx);
      wrapped_q   <= wrap_q;
      overflow_q  <= ovf_q;
    end
  end

  assign status_o.in_last_acc = in_acc && is_last_i;
  assign status_o.n_one       = (cnt_q == CNT_W'(1));
  assign status_o.less        = $signed(rd_a_q) < $signed(rd_b_q);
  assign status_o.ptr_one     = (ptr_q == IDX_W'(1));
  assign status_o.lo_ge_hi    = (lo_q >= hi_q);
  assign status_o.out_room    = !out_valid_q || !out_stall_i;
  assign status_o.ptr_last    = (ptr_q == last_idx);

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;
  assign wrapped_o   = wrapped_q;
  assign overflow_o  = overflow_q;

endmodule

// File: sv/next_permutation_engine_top.sv
// Next lexicographic permutation engine.
// Input channel (in_valid_i / in_stall_o): one element per transaction, with
// is_last_i high on the final element of a sequence. Up to 16 elements are
// kept; further elements are dropped and overflow_o is raised on the results.
// Output channel (out_valid_o / out_stall_i): one transaction per stored
// element, in order, out_last_o high on the final one, wrapped_o high when
// the input had no ascent and was returned in ascending order.
// Loading accepts one element per cycle. After the last element a
// microcoded sequencer runs the permutation over a buffer with two
// registered read ports and one write port: it scans back for the
// pivot, searches back for the swap partner, swaps the two, reverses
// the suffix pair by pair and emits each element in turn. Input is
// stalled from the last element until the sequencer returns to
// loading, through its next-step and finish states after the final
// result has been placed in the output register.
// The output register holds its transaction while out_stall_i is high; the
// sequencer waits at that point. Reset returns to loading with an empty
// buffer; there is no clearing pass.
module next_permutation_engine_top
  import npe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] elem_value_i,
  input  logic        is_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] out_value_o,
  output logic        out_last_o,
  output logic        wrapped_o,
  output logic        overflow_o
);

  dp_ctrl_t   ctrl;
  dp_status_t status;

  npe_sequencer u_sequencer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  npe_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .status_o     (status),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .elem_value_i (elem_value_i),
    .is_last_i    (is_last_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_value_o  (out_value_o),
    .out_last_o   (out_last_o),
    .wrapped_o    (wrapped_o),
    .overflow_o   (overflow_o)
  );

endmodule

// File: tb/sv/tb_next_permutation_engine_top.sv
module tb_next_permutation_engine_top
  import npe_pkg::*;
();

  localparam int ELEM_MAX = 32'h7fff_ffff;
  localparam int ELEM_MIN = 32'h8000_0000;

  typedef struct {
    logic [31:0] value;
    logic        last;
    logic        wrapped;
    logic        overflow;
  } perm_out_t;

  // Tracks the loaded sequence and queues the permutation it must produce.
  class perm_checker;
    elem_t     held [MAX_LEN];
    int        held_cnt;
    bit        dropped;
    perm_out_t pending [$];
    int        errors;

    function new();
      held_cnt = 0;
      dropped  = 1'b0;
      errors   = 0;
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    function void swap_held(int a, int b);
      elem_t t;
      t       = held[a];
      held[a] = held[b];
      held[b] = t;
    endfunction

    function void form_next_perm();
      int               pivot;
      bit               found;
      int               lo;
      int               hi;
      perm_out_t        r;
      logic signed [63:0] wide;
      pivot = 0;
      found = 1'b0;
      for (int i = held_cnt - 1; i > 0; i--) begin
        if ($signed(held[i-1]) < $signed(held[i])) begin
          pivot = i - 1;
          found = 1'b1;
          break;
        end
      end
      if (found) begin
        for (int i = held_cnt - 1; i > pivot; i--) begin
          if ($signed(held[pivot]) < $signed(held[i])) begin
            swap_held(pivot, i);
            break;
          end
        end
        lo = pivot + 1;
      end else begin
        lo = 0;
      end
      // The suffix is descending, so reversing it sorts it.
      hi = held_cnt - 1;
      while (lo < hi) begin
        swap_held(lo, hi);
        lo++;
        hi--;
      end
      for (int i = 0; i < held_cnt; i++) begin
        wide       = $signed(held[i]);
        r.value    = wide[31:0];
        r.last     = (i == held_cnt - 1);
        r.wrapped  = !found;
        r.overflow = dropped;
        pending.push_back(r);
      end
      held_cnt = 0;
      dropped  = 1'b0;
    endfunction

    function void absorb_element(logic [31:0] v, logic last);
      if (held_cnt < MAX_LEN) begin
        held[held_cnt] = v[ELEM_WIDTH-1:0];
        held_cnt++;
      end else begin
        dropped = 1'b1;
      end
      if (last) begin
        form_next_perm();
      end
    endfunction

    task match_output(logic [31:0] v, logic last, logic wrap, logic ovf);
      perm_out_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result, out_value %h", v));
        return;
      end
      e = pending.pop_front();
      if (v !== e.value) begin
        report($sformatf("out_value got %h want %h", v, e.value));
      end
      if (last !== e.last) begin
        report($sformatf("out_last got %b want %b", last, e.last));
      end
      if (wrap !== e.wrapped) begin
        report($sformatf("wrapped got %b want %b", wrap, e.wrapped));
      end
      if (ovf !== e.overflow) begin
        report($sformatf("overflow got %b want %b", ovf, e.overflow));
      end
    endtask
  endclass

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_stall_o;
  logic [31:0] elem_value_i = '0;
  logic        is_last_i    = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i  = 1'b0;
  logic [31:0] out_value_o;
  logic        out_last_o;
  logic        wrapped_o;
  logic        overflow_o;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_request   = 0;

  perm_checker sb;

  next_permutation_engine_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .elem_value_i (elem_value_i),
    .is_last_i    (is_last_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_value_o  (out_value_o),
    .out_last_o   (out_last_o),
    .wrapped_o    (wrapped_o),
    .overflow_o   (overflow_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #3600000;
    $display("status: fail");
    $finish;
  end

  task automatic send_elem(input logic [31:0] v, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    elem_value_i <= v;
    is_last_i    <= last;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) begin
      @(posedge clk_i);
    end
    sb.absorb_element(v, last);
  endtask

  task automatic send_seq(input int vals[$]);
    foreach (vals[i]) begin
      send_elem(vals[i], i == vals.size() - 1);
    end
  endtask

  // Lowers valid in the step of the last transaction and waits for the output.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // A length of zero picks one at random, mostly short, now and then past the buffer.
  function automatic void build_seq(input int want_len, output int vals[$]);
    int len;
    int pick;
    vals = {};
    pick = $urandom_range(99);
    if (want_len > 0) begin
      len = want_len;
    end else if (pick < 8) begin
      len = $urandom_range(20, 17);
    end else if (pick < 20) begin
      len = $urandom_range(16, 7);
    end else begin
      len = $urandom_range(6, 1);
    end
    repeat (len) begin
      case ($urandom_range(2))
        0: vals.push_back(int'($urandom_range(6)) - 3);
        1: vals.push_back(int'($urandom));
        default: begin
          case ($urandom_range(4))
            0: vals.push_back(ELEM_MAX);
            1: vals.push_back(ELEM_MIN);
            2: vals.push_back(0);
            3: vals.push_back(-1);
            default: vals.push_back(1);
          endcase
        end
      endcase
    end
    pick = $urandom_range(9);
    if (pick == 0) begin
      vals.rsort();
    end else if (pick == 1) begin
      vals.sort();
    end
  endfunction

  task automatic run_phase(input int send_pct, input int recv_pct, input int count);
    int done;
    int vals[$];
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    done = 0;
    while (done < count) begin
      build_seq(0, vals);
      send_seq(vals);
      done += vals.size();
    end
    drain_results();
  endtask

  initial begin
    int vals[$];
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single elements at the extremes, a pair each way, equal elements and short mixes.
    send_seq('{ELEM_MAX});
    send_seq('{ELEM_MIN});
    send_seq('{ELEM_MIN, ELEM_MAX});
    send_seq('{ELEM_MAX, ELEM_MIN});
    send_seq('{5, 5});
    send_seq('{1, 3, 2});
    send_seq('{3, 2, 1});
    send_seq('{0, -1, -1, 2});
    drain_results();

    // A completely full buffer, then a load that runs past it.
    build_seq(MAX_LEN, vals);
    send_seq(vals);
    build_seq(MAX_LEN + 2, vals);
    send_seq(vals);
    drain_results();

    run_phase(0, 0, 25);

    // Long hold-off on the output while the sender keeps offering transactions.
    hold_request = 400;
    repeat (3) begin
      build_seq(0, vals);
      send_seq(vals);
    end
    drain_results();

    run_phase(59, 0, 25);
    run_phase(0, 59, 25);
    run_phase(11, 11, 25);

    repeat (300) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
        sb.match_output(out_value_o, out_last_o, wrapped_o, overflow_o);
      end
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

endmodule

// File: filelist.f
sv/npe_pkg.sv
sv/npe_sequencer.sv
sv/npe_datapath.sv
sv/next_permutation_engine_top.sv
tb/sv/tb_next_permutation_engine_top.sv
